// ----- hw/rtl/estm_pkg.sv -----
// ---------------------------------------------------------------------------
// estm_pkg: shared constants for the envelope skew timing core
// Widths, cfg register indexes, the cfg struct and fixed scale and period constants.
// ---------------------------------------------------------------------------
package estm_pkg;
  localparam int DW = 32;
  localparam logic [31:0] HALF_SCALE = 32'h8000_0000;
  localparam logic [31:0] BIG_PERIOD = 32'h00FF_FFFF;
  localparam logic [0:0]  REG_LIMIT_SKEW      = 1'b0;
  localparam logic [0:0]  REG_LIMIT_SKEW_TIME = 1'b1;

  typedef struct packed {
    logic        limit;
    logic [30:0] limit_time;
  } estm_cfg_t;
endpackage

// ----- hw/rtl/envelope_skew_timing_core.sv -----
// Path from input transaction to result: multiply register, period divider,
// fall logic, rise register, increment dividers, output register.
// Throughput: one transaction per cycle; each divider is a row of 32
// one-bit cells. Stalls only while the output register is held.
// Reset: synchronous, clears all valid bits and cfg registers.
// ---------------------------------------------------------------------------
// envelope_skew_timing_core: top level
// Period scaling, skew split and phase increment generation.
// ---------------------------------------------------------------------------
module envelope_skew_timing_core import estm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [30:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // period[31:0], divide_amount[39:32], skew[47:40]
  input  logic [47:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // scaled_period, fall_len, rise_len, rise_increment, fall_increment
  // (32 each), zero_divide[160], zero pad
  output logic [167:0] m_tdata
);
  estm_cfg_t     cfg;
  logic          en;
  logic          v0;
  logic [DW-1:0] num0, den0;
  logic [7:0]    sk0;
  logic signed [7:0] amt;
  logic [39:0]   mul;
  logic          v1;
  logic [DW-1:0] div1;
  logic [7:0]    sk1;
  logic          fv;
  logic [DW-1:0] fp, ff;
  logic          rv;
  logic [DW-1:0] rp, rf, rr;
  logic          va, vb;
  logic [DW-1:0] qa, qb;
  logic          za;
  logic [3*DW-1:0] sb;
  logic          zr, zf;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign amt      = s_tdata[39:32];
  assign mul      = {8'd0, s_tdata[31:0]} * {32'd0, s_tdata[39:32]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LIMIT_SKEW:      cfg.limit <= cfg_data[0];
        REG_LIMIT_SKEW_TIME: cfg.limit_time <= cfg_data;
        default:             cfg <= cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      rv <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
      rv <= fv;
      m_tvalid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num0 <= (amt > 8'sd1) ? mul[DW-1:0] : s_tdata[31:0];
      den0 <= (amt < -8'sd1) ? {24'd0, 8'd0 - s_tdata[39:32]} : 32'd1;
      sk0  <= s_tdata[47:40];
    end
  end

  estm_div_chain #(.SW(8)) u_period (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v0), .in_num(num0), .in_den(den0), .in_side(sk0),
    .out_valid(v1), .out_quo(div1), .out_side(sk1)
  );

  estm_fall u_fall (
    .clk(clk), .rst(rst), .en(en), .cfg(cfg),
    .in_valid(v1), .in_period(div1), .in_skew(sk1),
    .out_valid(fv), .out_period(fp), .out_fall(ff)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      rp <= fp;
      rf <= ff;
      rr <= fp - ff;
    end
  end

  estm_div_chain #(.SW(1)) u_rise_inc (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(rv), .in_num(HALF_SCALE), .in_den(rr), .in_side(rr == '0),
    .out_valid(va), .out_quo(qa), .out_side(za)
  );

  estm_div_chain #(.SW(3*DW)) u_fall_inc (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(rv), .in_num(HALF_SCALE), .in_den(rf), .in_side({rr, rf, rp}),
    .out_valid(vb), .out_quo(qb), .out_side(sb)
  );

  assign zr = za;
  assign zf = sb[2*DW-1:DW] == '0;

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {7'd0, zr || zf,
                  zf ? HALF_SCALE : qb,
                  zr ? HALF_SCALE : qa,
                  sb};
    end
  end

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst) va == vb)
    else $error("increment dividers out of step");
  a_rise_sum: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[95:64] + m_tdata[63:32] == m_tdata[31:0]))
    else $error("rise plus fall differs from period");
  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[160]) |->
      (m_tdata[127:96] == HALF_SCALE || m_tdata[159:128] == HALF_SCALE))
    else $error("zero divide without forced increment");
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");
endmodule

// ----- hw/rtl/estm_div_cell.sv -----
// ---------------------------------------------------------------------------
// estm_div_cell: one restoring division step
// Shifts one dividend bit into the remainder and forms one quotient bit.
// ---------------------------------------------------------------------------
module estm_div_cell import estm_pkg::*; #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [DW-1:0] in_quo,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [DW-1:0] out_rem,
  output logic [DW-1:0] out_quo,
  output logic [DW-1:0] out_den,
  output logic [SW-1:0] out_side
);
  logic [DW:0] t;
  logic [DW:0] diff;
  logic        ge;

  assign t    = {in_rem, in_quo[DW-1]};
  assign ge   = t >= {1'b0, in_den};
  assign diff = t - {1'b0, in_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= ge ? diff[DW-1:0] : t[DW-1:0];
      out_quo  <= {in_quo[DW-2:0], ge};
      out_den  <= in_den;
      out_side <= in_side;
    end
  end
endmodule

// ----- hw/rtl/estm_div_chain.sv -----
// ---------------------------------------------------------------------------
// estm_div_chain: row of division cells
// One quotient bit per registered cell, advancing while en is high; side data rides along.
// ---------------------------------------------------------------------------
module estm_div_chain import estm_pkg::*; #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [DW-1:0] out_quo,
  output logic [SW-1:0] out_side
);
  logic          v   [0:DW];
  logic [DW-1:0] rem [0:DW];
  logic [DW-1:0] quo [0:DW];
  logic [DW-1:0] den [0:DW];
  logic [SW-1:0] sd  [0:DW];

  assign v[0]   = in_valid;
  assign rem[0] = '0;
  assign quo[0] = in_num;
  assign den[0] = in_den;
  assign sd[0]  = in_side;

  for (genvar i = 0; i < DW; i++) begin : g_cell
    estm_div_cell #(.SW(SW)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(v[i]), .in_rem(rem[i]), .in_quo(quo[i]), .in_den(den[i]),
      .in_side(sd[i]),
      .out_valid(v[i+1]), .out_rem(rem[i+1]), .out_quo(quo[i+1]),
      .out_den(den[i+1]), .out_side(sd[i+1])
    );
  end

  assign out_valid = v[DW];
  assign out_quo   = quo[DW];
  assign out_side  = sd[DW];
endmodule

// ----- hw/rtl/estm_fall.sv -----
// ---------------------------------------------------------------------------
// estm_fall: fall time from period and skew
// Three stages: products, subtractions and clamps, final selection.
// ---------------------------------------------------------------------------
module estm_fall import estm_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  estm_cfg_t     cfg,
  input  logic          in_valid,
  input  logic [DW-1:0] in_period,
  input  logic [7:0]    in_skew,
  output logic          out_valid,
  output logic [DW-1:0] out_period,
  output logic [DW-1:0] out_fall
);
  // stage 1
  logic          v1, norm1;
  logic [DW-1:0] p1, portion1, pm1;
  logic [7:0]    sk1;
  logic [16:0]   ulo1, uhi1;
  logic [39:0]   prod_hi, prod_lo;
  logic [7:0]    r;
  // stage 2
  logic          v2, norm2, uhi_gt2;
  logic [DW-1:0] p2, top2, port_hi2, pmu2, pl2, pml2, pm2, port_lo2;
  logic [7:0]    sk2;
  logic [DW-1:0] plo_raised;
  // stage 3
  logic [DW-1:0] fall_next;

  assign prod_hi = {8'd0, in_period[DW-1:8]} * {32'd0, in_skew};
  assign prod_lo = {8'd0, in_period} * {32'd0, in_skew};
  assign r       = 8'd255 - in_skew;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1       <= in_period;
      sk1      <= in_skew;
      norm1    <= !cfg.limit || (in_period < {cfg.limit_time, 1'b0});
      portion1 <= (in_period > BIG_PERIOD) ? prod_hi[DW-1:0] : prod_lo[DW+7:8];
      pm1      <= prod_hi[DW-1:0];
      ulo1     <= {({8'd0, in_skew} * {8'd0, in_skew}), 1'b0};
      uhi1     <= {({8'd0, r} * {8'd0, r}), 1'b0};
    end
  end

  assign plo_raised = (portion1 < 32'd50) ? 32'd50 : portion1;

  always_ff @(posedge clk) begin
    if (en) begin
      p2       <= p1;
      sk2      <= sk1;
      norm2    <= norm1;
      pm2      <= pm1;
      top2     <= p1 - 32'd20;
      port_hi2 <= (portion1 > (p1 - 32'd20)) ? (p1 - 32'd20) : portion1;
      uhi_gt2  <= {15'd0, uhi1} > (p1 - 32'd20);
      pmu2     <= p1 - {15'd0, uhi1};
      port_lo2 <= (plo_raised < {15'd0, ulo1}) ? plo_raised : {15'd0, ulo1};
      pl2      <= (portion1 < {1'b0, cfg.limit_time}) ? {1'b0, cfg.limit_time} : portion1;
      pml2     <= p1 - {1'b0, cfg.limit_time};
    end
  end

  always_comb begin
    if (sk2 > 8'd125 && sk2 <= 8'd129) begin
      fall_next = {1'b0, p2[DW-1:1]};
    end else if (!norm2) begin
      fall_next = (pl2 > pml2) ? pml2 : pl2;
    end else if (sk2 == 8'd0) begin
      fall_next = 32'd30;
    end else if (sk2 == 8'd1) begin
      fall_next = 32'd40;
    end else if (sk2 == 8'd2) begin
      fall_next = 32'd50;
    end else if (sk2 <= 8'd25) begin
      fall_next = port_lo2;
    end else if (sk2 == 8'd255) begin
      fall_next = top2;
    end else if (sk2 > 8'd200) begin
      fall_next = (uhi_gt2 || port_hi2 > pmu2) ? port_hi2 : pmu2;
    end else begin
      fall_next = pm2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_period <= p2;
      out_fall   <= fall_next;
    end
  end
endmodule
